>>> design/s3tc_pkg.sv
// shared types and constants for the s3tc block decoder
`timescale 1ns / 1ps

package s3tc_pkg;

  // block format codes
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // reciprocals for the alpha palette divides, scaled by 2^16
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP7      = 14'd9363;
  localparam logic [13:0] RECIP5      = 14'd13108;

  // one compressed block request
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] endpoint_one;
    logic [15:0] endpoint_two;
    logic [31:0] colour_codes;
    logic [7:0]  alpha_one;
    logic [7:0]  alpha_two;
    logic [47:0] alpha_codes;
  } s3tc_in_t;

  // one decoded texel
  typedef struct packed {
    logic [31:0] texel;
    logic [3:0]  texel_index;
    logic        last;
  } s3tc_out_t;

  // per texel work handed from the issue stage to the datapath
  typedef struct packed {
    logic [7:0] lo_r;
    logic [7:0] lo_g;
    logic [7:0] lo_b;
    logic [7:0] hi_r;
    logic [7:0] hi_g;
    logic [7:0] hi_b;
    logic       four_mode;
    logic [1:0] code;
    logic       dxt5;
    logic [2:0] aidx;
    logic [7:0] a1;
    logic [7:0] a2;
    logic       a_gt;
    logic [3:0] index;
    logic       last;
  } s3tc_issue_t;

endpackage

>>> design/s3tc_texel_pipe.sv
// three stage texel datapath: palette math, alpha divide, output register
`timescale 1ns / 1ps

module s3tc_texel_pipe
  import s3tc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        issue_valid,
  input  s3tc_issue_t issue,
  output logic        out_valid,
  output s3tc_out_t   out_data
);

  localparam logic [1:0] AK_DIRECT = 2'd0;
  localparam logic [1:0] AK_DIV7   = 2'd1;
  localparam logic [1:0] AK_DIV5   = 2'd2;

  // middle colours of four-colour mode and the three-colour average
  function automatic logic [7:0] mid_from_lo(input logic [7:0] lo, input logic [7:0] hi);
    logic signed [8:0] d;
    logic signed [8:0] s;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    s = (d >>> 1) - (d >>> 3);
    return 8'($signed({1'b0, lo}) + s);
  endfunction

  function automatic logic [7:0] mid_from_hi(input logic [7:0] lo, input logic [7:0] hi);
    logic signed [8:0] d;
    logic signed [8:0] s;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    s = (d >>> 1) - (d >>> 3);
    return 8'($signed({1'b0, hi}) - s);
  endfunction

  function automatic logic [7:0] average(input logic [7:0] lo, input logic [7:0] hi);
    logic [8:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} + 9'd1;
    return sum[8:1];
  endfunction

  typedef struct packed {
    logic [23:0] rgb;
    logic [7:0]  base_alpha;
    logic        dxt5;
    logic [1:0]  akind;
    logic [10:0] asum;
    logic [7:0]  adirect;
    logic [3:0]  index;
    logic        last;
  } s3tc_s2_t;

  s3tc_issue_t s1_r;
  logic        v1_r;
  s3tc_s2_t    s2_r, s2_nxt;
  logic        v2_r;
  s3tc_out_t   s3_r, s3_nxt;
  logic        v3_r;

  // stage 1: latch the issued texel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= issue;
    end
  end

  // stage 2 logic: colour pick and alpha weighted sum
  always_comb begin
    logic [7:0]  r, g, b;
    logic [3:0]  w1, w2;
    logic [10:0] p1, p2;
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    s2_nxt.base_alpha = 8'hFF;
    unique case (s1_r.code)
      2'd0: begin
        r = s1_r.lo_r; g = s1_r.lo_g; b = s1_r.lo_b;
      end
      2'd1: begin
        r = s1_r.hi_r; g = s1_r.hi_g; b = s1_r.hi_b;
      end
      2'd2: begin
        if (s1_r.four_mode) begin
          r = mid_from_lo(s1_r.lo_r, s1_r.hi_r);
          g = mid_from_lo(s1_r.lo_g, s1_r.hi_g);
          b = mid_from_lo(s1_r.lo_b, s1_r.hi_b);
        end else begin
          r = average(s1_r.lo_r, s1_r.hi_r);
          g = average(s1_r.lo_g, s1_r.hi_g);
          b = average(s1_r.lo_b, s1_r.hi_b);
        end
      end
      2'd3: begin
        if (s1_r.four_mode) begin
          r = mid_from_hi(s1_r.lo_r, s1_r.hi_r);
          g = mid_from_hi(s1_r.lo_g, s1_r.hi_g);
          b = mid_from_hi(s1_r.lo_b, s1_r.hi_b);
        end else begin
          r = s1_r.hi_r; g = s1_r.hi_g; b = s1_r.hi_b;
          s2_nxt.base_alpha = 8'h00;
        end
      end
      default: begin
        r = s1_r.lo_r; g = s1_r.lo_g; b = s1_r.lo_b;
      end
    endcase
    s2_nxt.rgb = {r, g, b};

    // alpha palette entry as a weighted sum still to be divided
    w2 = {1'b0, s1_r.aidx} - 4'd1;
    if (s1_r.a_gt) begin
      w1 = 4'd8 - {1'b0, s1_r.aidx};
    end else begin
      w1 = 4'd6 - {1'b0, s1_r.aidx};
    end
    p1 = 11'(w1) * 11'(s1_r.a1);
    p2 = 11'(w2) * 11'(s1_r.a2);
    s2_nxt.asum    = p1 + p2;
    s2_nxt.akind   = AK_DIRECT;
    s2_nxt.adirect = 8'd0;
    priority if (s1_r.aidx == 3'd0) begin
      s2_nxt.adirect = s1_r.a1;
    end else if (s1_r.aidx == 3'd1) begin
      s2_nxt.adirect = s1_r.a2;
    end else if (s1_r.a_gt) begin
      s2_nxt.akind = AK_DIV7;
    end else if (s1_r.aidx == 3'd6) begin
      s2_nxt.adirect = 8'd0;
    end else if (s1_r.aidx == 3'd7) begin
      s2_nxt.adirect = 8'hFF;
    end else begin
      s2_nxt.akind = AK_DIV5;
    end

    s2_nxt.dxt5  = s1_r.dxt5;
    s2_nxt.index = s1_r.index;
    s2_nxt.last  = s1_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  // stage 3 logic: divide by reciprocal multiply and pack argb
  always_comb begin
    logic [13:0] recip;
    logic [24:0] prod;
    logic [7:0]  alpha;
    if (s2_r.akind == AK_DIV7) begin
      recip = RECIP7;
    end else begin
      recip = RECIP5;
    end
    prod = 25'(s2_r.asum) * 25'(recip);
    if (s2_r.akind == AK_DIRECT) begin
      alpha = s2_r.adirect;
    end else begin
      alpha = prod[RECIP_SHIFT +: 8];
    end
    if (!s2_r.dxt5) begin
      alpha = s2_r.base_alpha;
    end
    s3_nxt.texel       = {alpha, s2_r.rgb};
    s3_nxt.texel_index = s2_r.index;
    s3_nxt.last        = s2_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

>>> design/s3tc_block_decoder.sv
// top level of the s3tc block decoder: block register, texel sequencer, datapath
`timescale 1ns / 1ps

// One request on the in_ channel is one compressed 4x4 block (DXT1, DXT3
// colour part, or DXT5). The block answers with sixteen requests on the out_
// channel, one texel each, in row order, carrying the ARGB word, the texel
// index and a last flag on the sixteenth.
// A block is held in a block register while a 4-bit counter issues one texel
// per cycle, save while the datapath is held, into a three stage datapath
// (colour pick and alpha sum, alpha divide, output register). The first texel
// passes the block register and the three datapath registers before it is
// valid. The next block is taken in the cycle the sixteenth texel of the
// previous one is issued, so blocks leave back to back, one texel per cycle.
// Reset clears the counter state and all valid bits; no block is pending.
// While out_stall is high with a texel waiting, the whole datapath and the
// sequencer hold, and in_stall is raised for as long as that lasts.

module s3tc_block_decoder
  import s3tc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  s3tc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output s3tc_out_t out_data
);

  s3tc_in_t    blk_r;
  logic        busy_r;
  logic [3:0]  cnt_r;
  logic        adv;
  logic        issue_go;
  logic        in_take;
  s3tc_issue_t issue;
  logic [4:0]  coff;
  logic [5:0]  aoff;

  // pipeline moves when the output register is empty or being taken
  assign adv      = !out_valid || !out_stall;
  assign issue_go = busy_r && adv;
  assign in_stall = !(adv && (!busy_r || cnt_r == 4'd15));
  assign in_take  = in_valid && !in_stall;

  // block register and texel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (in_take) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd0;
    end else if (issue_go) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      blk_r <= in_data;
    end
  end

  // per texel fields: widened endpoints, mode and index bits
  assign coff = {cnt_r, 1'b0};
  assign aoff = 6'(cnt_r) * 6'd3;

  always_comb begin
    issue.lo_r = {blk_r.endpoint_one[4:0], blk_r.endpoint_one[4:2]};
    issue.lo_g = {blk_r.endpoint_one[10:5], blk_r.endpoint_one[10:9]};
    issue.lo_b = {blk_r.endpoint_one[15:11], blk_r.endpoint_one[15:13]};
    issue.hi_r = {blk_r.endpoint_two[4:0], blk_r.endpoint_two[4:2]};
    issue.hi_g = {blk_r.endpoint_two[10:5], blk_r.endpoint_two[10:9]};
    issue.hi_b = {blk_r.endpoint_two[15:11], blk_r.endpoint_two[15:13]};
    issue.four_mode = (blk_r.endpoint_one > blk_r.endpoint_two) || (blk_r.op != FMT_DXT1);
    issue.code  = blk_r.colour_codes[coff +: 2];
    issue.dxt5  = (blk_r.op == FMT_DXT5);
    issue.aidx  = blk_r.alpha_codes[aoff +: 3];
    issue.a1    = blk_r.alpha_one;
    issue.a2    = blk_r.alpha_two;
    issue.a_gt  = blk_r.alpha_one > blk_r.alpha_two;
    issue.index = cnt_r;
    issue.last  = (cnt_r == 4'd15);
  end

  // texel datapath
  s3tc_texel_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .issue_valid (issue_go),
    .issue       (issue),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
